FILE: hdl/assert_macros.svh
// Assertion helpers shared by the RTL of the pixel codec.
// Include guard keeps the macros defined once per compilation unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/lsbsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbsc_pkg
// Shared types, register indexes and helper functions of the LSB pixel codec.
// ----------------------------------------------------------------------------
package lsbsc_pkg;

  localparam int MAX_WIDTH_DEFAULT = 4096;
  localparam int IMAGE_WIDTH_RESET = 640;

  localparam int CH_W     = 8;
  localparam int IMG_W_W  = 13;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 13;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CODEC_MODE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 8'd1;

  // Codec modes.
  localparam logic MODE_DECODE = 1'b0;
  localparam logic MODE_ENCODE = 1'b1;

  // Position of a used pixel inside its group of three.
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  typedef struct packed {
    logic               codec_mode;
    logic [IMG_W_W-1:0] eff_width;   // image width capped at the maximum
    logic [IMG_W_W-1:0] used_width;  // eff_width rounded down to a multiple of three
  } cfg_t;

  // Remainder by three: base-4 digits sum to the same residue.
  function automatic logic [1:0] mod3_13(input logic [IMG_W_W-1:0] v);
    logic [IMG_W_W:0] p;
    logic [4:0]       s;
    logic [3:0]       t;
    logic [1:0]       r;
    p = {1'b0, v};
    s = '0;
    for (int i = 0; i < 7; i++) begin
      s = s + 5'(p[2*i +: 2]);
    end
    t = 4'(s[1:0]) + 4'(s[3:2]) + 4'(s[4]);
    if (t >= 4'd6) begin
      r = 2'(t - 4'd6);
    end else if (t >= 4'd3) begin
      r = 2'(t - 4'd3);
    end else begin
      r = 2'(t);
    end
    return r;
  endfunction

endpackage

FILE: hdl/lsbsc_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbsc interfaces
// Pixel request, result and configuration write channels of the codec.
// ----------------------------------------------------------------------------
interface lsbsc_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] msg_byte;
  logic       msg_last;
  logic       frame_start;

  modport source (output valid, red, green, blue, msg_byte, msg_last, frame_start,
                  input ready);
  modport sink   (input valid, red, green, blue, msg_byte, msg_last, frame_start,
                  output ready);
endinterface

interface lsbsc_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       byte_consumed;
  logic [7:0] decoded_byte;
  logic       decoded_valid;
  logic       message_end;

  modport source (output valid, out_red, out_green, out_blue, byte_consumed,
                  decoded_byte, decoded_valid, message_end, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, byte_consumed,
                  decoded_byte, decoded_valid, message_end, output ready);
endinterface

interface lsbsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [12:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/lsbsc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbsc_cfg
// Configuration registers; derives the capped and used row widths on write.
// ----------------------------------------------------------------------------
module lsbsc_cfg #(
  parameter int MAX_WIDTH = lsbsc_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  lsbsc_cfg_if.sink         cfg,
  output lsbsc_pkg::cfg_t   cfg_state
);

  localparam int CAP_WIDTH  = (MAX_WIDTH > 8191) ? 8191 : MAX_WIDTH;
  localparam int RST_WIDTH  = (lsbsc_pkg::IMAGE_WIDTH_RESET > CAP_WIDTH) ?
                              CAP_WIDTH : lsbsc_pkg::IMAGE_WIDTH_RESET;
  localparam int RST_USED   = RST_WIDTH - (RST_WIDTH % 3);

  logic [lsbsc_pkg::IMG_W_W-1:0] width_capped;
  logic [lsbsc_pkg::IMG_W_W-1:0] width_used;

  assign cfg.ready = 1'b1;

  always_comb begin
    if (int'(cfg.data) > CAP_WIDTH) begin
      width_capped = lsbsc_pkg::IMG_W_W'(CAP_WIDTH);
    end else begin
      width_capped = cfg.data;
    end
    width_used = width_capped
               - lsbsc_pkg::IMG_W_W'(lsbsc_pkg::mod3_13(width_capped));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_state.codec_mode <= lsbsc_pkg::MODE_DECODE;
      cfg_state.eff_width  <= lsbsc_pkg::IMG_W_W'(RST_WIDTH);
      cfg_state.used_width <= lsbsc_pkg::IMG_W_W'(RST_USED);
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        lsbsc_pkg::REG_CODEC_MODE: begin
          cfg_state.codec_mode <= cfg.data[0];
        end
        lsbsc_pkg::REG_IMAGE_WIDTH: begin
          cfg_state.eff_width  <= width_capped;
          cfg_state.used_width <= width_used;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: hdl/lsb_stego_pixel_codec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsb_stego_pixel_codec
// Hides or recovers one message byte per group of three RGB pixels in the
// channel LSBs, with an end mark in the last blue LSB of each group.
// ----------------------------------------------------------------------------
// A request's result is registered and shows in the cycle after it is accepted.
// Throughput: one pixel per cycle while results are taken; the output register
// frees as it is taken. The single result register sets that figure; the input
// side stalls only while a result waits. Reset clears position, phase, end flag
// and output valid and loads decode mode, row width 640 (capped at MAX_WIDTH).
module lsb_stego_pixel_codec #(
  parameter int MAX_WIDTH = lsbsc_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  lsbsc_pixel_if.sink     pix_in,
  lsbsc_result_if.source  pix_out,
  lsbsc_cfg_if.sink       cfg
);

`include "assert_macros.svh"

  localparam int COL_FULL = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int COL_W    = (COL_FULL > lsbsc_pkg::IMG_W_W) ? lsbsc_pkg::IMG_W_W : COL_FULL;

  lsbsc_pkg::cfg_t cfg_state;

  lsbsc_cfg #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cfg_state (cfg_state)
  );

  // Stream position state.
  logic [COL_W-1:0] column_index;
  logic [1:0]       group_phase;
  logic [5:0]       bit_gather;
  logic             finished;

  // Result register.
  logic       out_valid;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       out_consumed;
  logic [7:0] out_dbyte;
  logic       out_dvalid;
  logic       out_mend;

  logic accept;

  logic [COL_W-1:0]              col_cur;
  logic [1:0]                    ph_cur;
  logic [5:0]                    bg_cur;
  logic                          fin_cur;
  logic [lsbsc_pkg::IMG_W_W-1:0] col_ext;
  logic [lsbsc_pkg::IMG_W_W-1:0] col_plus;
  logic                          active;
  logic [2:0]                    rgb_lsb;

  logic [7:0]       red_next;
  logic [7:0]       green_next;
  logic [7:0]       blue_next;
  logic             consumed_next;
  logic [7:0]       dbyte_next;
  logic             dvalid_next;
  logic             mend_next;
  logic [COL_W-1:0] column_index_next;
  logic [1:0]       group_phase_next;
  logic [5:0]       bit_gather_next;
  logic             finished_next;

  assign pix_in.ready = !out_valid || pix_out.ready;
  assign accept       = pix_in.valid && pix_in.ready;

  always_comb begin
    // A frame start restarts the stream before this pixel is handled.
    col_cur  = pix_in.frame_start ? '0   : column_index;
    ph_cur   = pix_in.frame_start ? lsbsc_pkg::PH_FIRST : group_phase;
    bg_cur   = pix_in.frame_start ? '0   : bit_gather;
    fin_cur  = pix_in.frame_start ? 1'b0 : finished;

    col_ext  = lsbsc_pkg::IMG_W_W'(col_cur);
    col_plus = col_ext + lsbsc_pkg::IMG_W_W'(1);
    active   = (col_ext < cfg_state.used_width) && !fin_cur;
    rgb_lsb  = {pix_in.red[0], pix_in.green[0], pix_in.blue[0]};

    red_next         = pix_in.red;
    green_next       = pix_in.green;
    blue_next        = pix_in.blue;
    consumed_next    = 1'b0;
    dbyte_next       = '0;
    dvalid_next      = 1'b0;
    mend_next        = 1'b0;
    group_phase_next = ph_cur;
    bit_gather_next  = bg_cur;
    finished_next    = fin_cur;

    if (active) begin
      if (cfg_state.codec_mode == lsbsc_pkg::MODE_ENCODE) begin
        case (ph_cur)
          lsbsc_pkg::PH_FIRST: begin
            red_next[0]   = pix_in.msg_byte[7];
            green_next[0] = pix_in.msg_byte[6];
            blue_next[0]  = pix_in.msg_byte[5];
          end
          lsbsc_pkg::PH_SECOND: begin
            red_next[0]   = pix_in.msg_byte[4];
            green_next[0] = pix_in.msg_byte[3];
            blue_next[0]  = pix_in.msg_byte[2];
          end
          default: begin
            red_next[0]   = pix_in.msg_byte[1];
            green_next[0] = pix_in.msg_byte[0];
            blue_next[0]  = pix_in.msg_last;
            consumed_next = 1'b1;
            mend_next     = pix_in.msg_last;
            finished_next = pix_in.msg_last;
          end
        endcase
      end else begin
        case (ph_cur)
          lsbsc_pkg::PH_FIRST: begin
            bit_gather_next = {3'b000, rgb_lsb};
          end
          lsbsc_pkg::PH_SECOND: begin
            bit_gather_next = {bg_cur[2:0], rgb_lsb};
          end
          default: begin
            dbyte_next    = {bg_cur, pix_in.red[0], pix_in.green[0]};
            dvalid_next   = 1'b1;
            mend_next     = pix_in.blue[0];
            finished_next = pix_in.blue[0];
          end
        endcase
      end
      // Phase values above the third wrap like the third.
      if (ph_cur >= lsbsc_pkg::PH_THIRD) begin
        group_phase_next = lsbsc_pkg::PH_FIRST;
      end else begin
        group_phase_next = ph_cur + 2'd1;
      end
    end

    if (col_plus >= cfg_state.eff_width) begin
      column_index_next = '0;
    end else begin
      column_index_next = COL_W'(col_plus);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      group_phase  <= lsbsc_pkg::PH_FIRST;
      bit_gather   <= '0;
      finished     <= 1'b0;
      out_valid    <= 1'b0;
    end else if (accept) begin
      column_index <= column_index_next;
      group_phase  <= group_phase_next;
      bit_gather   <= bit_gather_next;
      finished     <= finished_next;
      out_valid    <= 1'b1;
    end else if (pix_out.ready) begin
      out_valid    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_red      <= red_next;
      out_green    <= green_next;
      out_blue     <= blue_next;
      out_consumed <= consumed_next;
      out_dbyte    <= dbyte_next;
      out_dvalid   <= dvalid_next;
      out_mend     <= mend_next;
    end
  end

  assign pix_out.valid         = out_valid;
  assign pix_out.out_red       = out_red;
  assign pix_out.out_green     = out_green;
  assign pix_out.out_blue      = out_blue;
  assign pix_out.byte_consumed = out_consumed;
  assign pix_out.decoded_byte  = out_dbyte;
  assign pix_out.decoded_valid = out_dvalid;
  assign pix_out.message_end   = out_mend;

  // A finished group always returns the phase to the first pixel.
  `ASSERT_CLK(a_group_wraps, clk, rst,
    accept && (consumed_next || dvalid_next) |=> group_phase == lsbsc_pkg::PH_FIRST,
    "group phase did not wrap after a completed byte")

  // Encode and decode flags never appear on the same result.
  `ASSERT_CLK(a_flags_exclusive, clk, rst,
    out_valid |-> !(out_consumed && out_dvalid),
    "byte_consumed and decoded_valid both set")

  // The end flag is only raised by a pixel that carried the end mark.
  `ASSERT_CLK(a_end_source, clk, rst,
    $rose(finished) |-> $past(accept && mend_next),
    "end flag set without a final byte")

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LSB pixel codec. A local model of the codec
// predicts every output pixel from the accepted requests and the register
// settings. A monitor compares each result with the oldest prediction. Both
// sides of the stream idle at random, and the result side once holds off long
// enough to back up the input.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MAX_W          = lsbsc_pkg::MAX_WIDTH_DEFAULT;
  localparam int RANDOM_ITEMS   = 330;
  localparam int MAX_IDLE       = 18;
  localparam int HOLD_CYCLES    = 80;
  localparam int RESULT_LATENCY = 1;
  localparam int DRAIN_LIMIT    = 2000;
  localparam longint TIMEOUT_NS = 5_000_000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] msg_byte;
    logic       msg_last;
    logic       frame_start;
  } pixel_req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       consumed;
    logic [7:0] dbyte;
    logic       dvalid;
    logic       mend;
  } pixel_res_t;

  logic clk;
  logic rst;

  lsbsc_pixel_if  pix_in();
  lsbsc_result_if pix_out();
  lsbsc_cfg_if    cfg();

  lsb_stego_pixel_codec #(
    .MAX_WIDTH(MAX_W)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .pix_in (pix_in),
    .pix_out(pix_out),
    .cfg    (cfg)
  );

  // Local copy of the codec state and its registers.
  logic        cfg_mode;
  logic [12:0] cfg_width;
  int          pos_column;
  logic [1:0]  pos_phase;
  logic [5:0]  lsb_gather;
  logic        msg_done;

  pixel_res_t expected_pixels[$];
  int         fail_count;
  bit         src_idle_on;
  bit         sink_idle_on;
  int         sink_wait;
  bit         hold_active;
  event       start_hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_top: FAIL");
    $finish;
  end

  task automatic report_error(input string msg);
    fail_count++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      report_error($sformatf("%s expected 0x%0h got 0x%0h", name, want, got));
    end
  endtask

  function automatic pixel_res_t codec_predict(input pixel_req_t p);
    pixel_res_t r;
    int         w_eff;
    int         used;
    logic [2:0] lsbs;
    r = '0;
    r.red   = p.red;
    r.green = p.green;
    r.blue  = p.blue;
    if (p.frame_start) begin
      pos_column = 0;
      pos_phase  = lsbsc_pkg::PH_FIRST;
      lsb_gather = '0;
      msg_done   = 1'b0;
    end
    w_eff = (int'(cfg_width) > MAX_W) ? MAX_W : int'(cfg_width);
    used  = w_eff - (w_eff % 3);
    if (pos_column < used && !msg_done) begin
      if (cfg_mode == lsbsc_pkg::MODE_ENCODE) begin
        case (pos_phase)
          lsbsc_pkg::PH_FIRST: begin
            r.red[0]   = p.msg_byte[7];
            r.green[0] = p.msg_byte[6];
            r.blue[0]  = p.msg_byte[5];
          end
          lsbsc_pkg::PH_SECOND: begin
            r.red[0]   = p.msg_byte[4];
            r.green[0] = p.msg_byte[3];
            r.blue[0]  = p.msg_byte[2];
          end
          default: begin
            r.red[0]   = p.msg_byte[1];
            r.green[0] = p.msg_byte[0];
            r.blue[0]  = p.msg_last;
            r.consumed = 1'b1;
            r.mend     = p.msg_last;
            msg_done   = p.msg_last;
          end
        endcase
      end else begin
        lsbs = {p.red[0], p.green[0], p.blue[0]};
        case (pos_phase)
          lsbsc_pkg::PH_FIRST:  lsb_gather = {3'b000, lsbs};
          lsbsc_pkg::PH_SECOND: lsb_gather = {lsb_gather[2:0], lsbs};
          default: begin
            r.dbyte  = {lsb_gather, p.red[0], p.green[0]};
            r.dvalid = 1'b1;
            r.mend   = p.blue[0];
            msg_done = p.blue[0];
          end
        endcase
      end
      pos_phase = (pos_phase >= lsbsc_pkg::PH_THIRD) ? lsbsc_pkg::PH_FIRST
                                                     : pos_phase + 2'd1;
    end
    if (pos_column + 1 >= w_eff) begin
      pos_column = 0;
    end else begin
      pos_column = pos_column + 1;
    end
    return r;
  endfunction

  // Result side: ready is decided at the falling edge, results are taken at the rising one.
  initial begin : result_ready_drive
    pix_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst || hold_active) begin
        pix_out.ready <= 1'b0;
      end else if (sink_wait > 0) begin
        pix_out.ready <= 1'b0;
        sink_wait = sink_wait - 1;
      end else begin
        pix_out.ready <= 1'b1;
      end
    end
  end

  initial begin : hold_off_counter
    hold_active = 1'b0;
    forever begin
      @(start_hold);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active = 1'b0;
    end
  end

  always @(posedge clk) begin : result_monitor
    pixel_res_t want;
    if (!rst && pix_out.valid && pix_out.ready) begin
      if (expected_pixels.size() == 0) begin
        report_error("result with no request pending");
      end else begin
        want = expected_pixels.pop_front();
        check_field("out_red", want.red, pix_out.out_red);
        check_field("out_green", want.green, pix_out.out_green);
        check_field("out_blue", want.blue, pix_out.out_blue);
        check_field("byte_consumed", want.consumed, pix_out.byte_consumed);
        check_field("decoded_byte", want.dbyte, pix_out.decoded_byte);
        check_field("decoded_valid", want.dvalid, pix_out.decoded_valid);
        check_field("message_end", want.mend, pix_out.message_end);
      end
      sink_wait = sink_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    end
  end

  task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                            input logic [7:0] blue, input logic [7:0] msg_byte,
                            input logic msg_last, input logic frame_start,
                            output pixel_res_t res);
    int         gap;
    pixel_req_t req;
    gap = src_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      @(negedge clk);
      pix_in.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    pix_in.valid       <= 1'b1;
    pix_in.red         <= red;
    pix_in.green       <= green;
    pix_in.blue        <= blue;
    pix_in.msg_byte    <= msg_byte;
    pix_in.msg_last    <= msg_last;
    pix_in.frame_start <= frame_start;
    do @(posedge clk); while (!pix_in.ready);
    req = '{red: red, green: green, blue: blue, msg_byte: msg_byte,
            msg_last: msg_last, frame_start: frame_start};
    res = codec_predict(req);
    expected_pixels.push_back(res);
  endtask

  // Stops offering requests and waits until every predicted result is taken.
  task automatic wait_results_drained();
    int n;
    @(negedge clk);
    pix_in.valid <= 1'b0;
    n = 0;
    while (expected_pixels.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (expected_pixels.size() != 0) begin
      report_error($sformatf("%0d results never arrived", expected_pixels.size()));
      expected_pixels.delete();
    end
    repeat (RESULT_LATENCY + 1) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [12:0] val);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    if (idx == lsbsc_pkg::REG_CODEC_MODE) begin
      cfg_mode = val[0];
    end else if (idx == lsbsc_pkg::REG_IMAGE_WIDTH) begin
      cfg_width = val;
    end
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic set_codec(input logic mode, input logic [12:0] width);
    wait_results_drained();
    write_reg(lsbsc_pkg::REG_CODEC_MODE, {12'd0, mode});
    write_reg(lsbsc_pkg::REG_IMAGE_WIDTH, width);
  endtask

  // Decode mode and a width of 640 must hold straight out of reset.
  task automatic test_reset_defaults();
    pixel_res_t res;
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, res);
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, res);
    send_pixel(8'h01, 8'h00, 8'h01, 8'h5A, 1'b0, 1'b0, res);
  endtask

  // Width 4 leaves one skipped column per row; the second byte ends the message.
  task automatic test_encode_message();
    pixel_res_t res;
    logic [7:0] msg;
    logic       last;
    logic [7:0] shade;
    set_codec(lsbsc_pkg::MODE_ENCODE, 13'd4);
    msg  = 8'hFF;
    last = 1'b0;
    for (int i = 0; i < 8; i++) begin
      shade = i[0] ? 8'hFF : 8'h00;
      send_pixel(shade, ~shade, shade, msg, last, i == 0, res);
      if (res.consumed) begin
        msg  = 8'h00;
        last = 1'b1;
      end
    end
  endtask

  task automatic test_decode_message();
    pixel_res_t res;
    set_codec(lsbsc_pkg::MODE_DECODE, 13'd4);
    for (int i = 0; i < 8; i++) begin
      send_pixel({7'h7F, i[0]}, {7'h00, i[1]}, {7'h55, i == 6 || i == 7},
                 8'($urandom), 1'($urandom), i == 0 || i == 7, res);
    end
  endtask

  // Widths below three skip every pixel; widths above the maximum are capped.
  task automatic test_narrow_and_capped_width();
    pixel_res_t res;
    set_codec(lsbsc_pkg::MODE_DECODE, 13'd0);
    send_pixel(8'h01, 8'h01, 8'h01, 8'h00, 1'b0, 1'b1, res);
    set_codec(lsbsc_pkg::MODE_ENCODE, 13'd1);
    send_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b1, res);
    wait_results_drained();
    write_reg(lsbsc_pkg::REG_IMAGE_WIDTH, 13'd2);
    send_pixel(8'hFE, 8'hFE, 8'hFE, 8'hFF, 1'b1, 1'b0, res);
    wait_results_drained();
    write_reg(lsbsc_pkg::REG_IMAGE_WIDTH, 13'h1FFF);
    send_pixel(8'h00, 8'hFF, 8'h00, 8'hA5, 1'b0, 1'b1, res);
  endtask

  // A group begun in encode mode is finished in decode mode.
  task automatic test_mode_change_in_group();
    pixel_res_t res;
    set_codec(lsbsc_pkg::MODE_ENCODE, 13'd3);
    send_pixel(8'h10, 8'h20, 8'h30, 8'hE0, 1'b0, 1'b1, res);
    wait_results_drained();
    write_reg(lsbsc_pkg::REG_CODEC_MODE, {12'd0, lsbsc_pkg::MODE_DECODE});
    send_pixel(8'h01, 8'h00, 8'h01, 8'h00, 1'b0, 1'b0, res);
    send_pixel(8'h01, 8'h01, 8'h00, 8'h00, 1'b0, 1'b0, res);
  endtask

  // The result side holds off while requests keep coming.
  task automatic test_output_backpressure();
    pixel_res_t res;
    logic [7:0] msg;
    set_codec(lsbsc_pkg::MODE_ENCODE, 13'd6);
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    msg = 8'($urandom);
    -> start_hold;
    for (int i = 0; i < 30; i++) begin
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom), msg, 1'b0, i == 0, res);
      if (res.consumed) begin
        msg = 8'($urandom);
      end
    end
  endtask

  // Mostly whole frames with well-formed messages, plus stray frame starts,
  // message bytes that change before use, and mode flips inside a frame.
  task automatic test_random_frames();
    pixel_res_t  res;
    int          sent;
    int          npix;
    int          bytes_left;
    int          flip_at;
    logic        mode;
    logic [12:0] width;
    logic [7:0]  msg;
    logic [7:0]  mb;
    logic [7:0]  blue;
    logic        last;
    logic        fs;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mode = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 19))
        0:       width = 13'($urandom_range(0, 2));
        1:       width = 13'($urandom_range(4096, 8191));
        default: width = 13'($urandom_range(3, 16));
      endcase
      set_codec(mode, width);
      src_idle_on  = ($urandom_range(0, 3) != 0);
      sink_idle_on = ($urandom_range(0, 3) != 0);
      npix    = $urandom_range(8, 40);
      flip_at = ($urandom_range(0, 6) == 0) ? $urandom_range(1, npix - 1) : -1;
      msg        = 8'($urandom);
      bytes_left = $urandom_range(0, 5);
      for (int i = 0; i < npix; i++) begin
        if (i == flip_at) begin
          wait_results_drained();
          write_reg(lsbsc_pkg::REG_CODEC_MODE, {12'd0, ~cfg_mode});
        end
        mb   = msg;
        last = (bytes_left == 0);
        if ($urandom_range(0, 19) == 0) begin
          mb   = 8'($urandom);
          last = 1'($urandom);
        end
        // In decode mode a set blue LSB on the last pixel of a group ends the message, so keep it rare.
        blue = 8'($urandom);
        if ($urandom_range(0, 5) != 0) begin
          blue[0] = 1'b0;
        end
        fs = (i == 0) || ($urandom_range(0, 29) == 0);
        send_pixel(8'($urandom), 8'($urandom), blue, mb, last, fs, res);
        if (res.consumed) begin
          msg        = 8'($urandom);
          bytes_left = (bytes_left > 0) ? bytes_left - 1 : $urandom_range(0, 5);
        end
        sent++;
      end
    end
  endtask

  initial begin : run_tests
    rst                = 1'b1;
    fail_count         = 0;
    sink_wait          = 0;
    src_idle_on        = 1'b0;
    sink_idle_on       = 1'b0;
    pix_in.valid       = 1'b0;
    pix_in.red         = '0;
    pix_in.green       = '0;
    pix_in.blue        = '0;
    pix_in.msg_byte    = '0;
    pix_in.msg_last    = 1'b0;
    pix_in.frame_start = 1'b0;
    cfg.valid          = 1'b0;
    cfg.index          = '0;
    cfg.data           = '0;
    cfg_mode           = lsbsc_pkg::MODE_DECODE;
    cfg_width          = 13'(lsbsc_pkg::IMAGE_WIDTH_RESET);
    pos_column         = 0;
    pos_phase          = lsbsc_pkg::PH_FIRST;
    lsb_gather         = '0;
    msg_done           = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_encode_message();
    test_decode_message();
    test_narrow_and_capped_width();
    test_mode_change_in_group();
    test_output_backpressure();
    test_random_frames();
    wait_results_drained();

    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/lsbsc_pkg.sv
hdl/lsbsc_ifs.sv
hdl/lsbsc_cfg.sv
hdl/lsb_stego_pixel_codec.sv
bench/tb_top.sv
